FILE: hdl/core_count_hotplug_decider_top_assert.svh
// Assertion macros used by the checker file.
`ifndef CORE_COUNT_HOTPLUG_DECIDER_TOP_ASSERT_SVH
`define CORE_COUNT_HOTPLUG_DECIDER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CCHD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cchd assertion failed");

// Next-cycle implication, disabled during reset.
`define CCHD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cchd assertion failed");

`endif

FILE: hdl/cchd_pkg.sv
// Types and constants of the core count hotplug decider.
package cchd_pkg;

  localparam int LOAD_W     = 7;
  localparam int FREQ_W     = 12;
  localparam int MS_W       = 16;
  localparam int TASK_W     = 8;
  localparam int CNT_W      = 3;
  localparam int WIN_W      = 14;
  localparam int MF_W       = 12;
  localparam int LF_W       = 21;
  localparam int TIME_W     = 9;
  localparam int AVG_W      = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int TX_W       = 17;

  localparam logic [TIME_W-1:0] TIME_CAP  = 9'd500;
  localparam logic [FREQ_W-1:0] UP1_FREQ  = 12'd998;
  localparam logic [FREQ_W-1:0] UP23_FREQ = 12'd1094;
  localparam logic [LOAD_W-1:0] UP1_LOAD  = 7'd80;
  localparam logic [LOAD_W:0]   DN2_LOAD  = 8'd80;

  // Task averages compared as 100 * sum against divisor * limit bounds.
  localparam logic [TX_W-1:0] UP1_TASKS = 17'd750;
  localparam logic [TX_W-1:0] DN2_TASKS = 17'd602;
  localparam logic [TX_W-1:0] UP2_TASKS = 17'd700;
  localparam logic [TX_W-1:0] DN3_TASKS = 17'd902;
  localparam logic [TX_W-1:0] UP3_TASKS = 17'd1350;
  localparam logic [TX_W-1:0] DN4_TASKS = 17'd1202;

  localparam logic [AVG_W-1:0] K80  = 21'd80;
  localparam logic [AVG_W-1:0] K150 = 21'd150;
  localparam logic [AVG_W-1:0] K160 = 21'd160;
  localparam logic [AVG_W-1:0] K200 = 21'd200;
  localparam logic [AVG_W-1:0] K240 = 21'd240;

  localparam logic [MF_W-1:0]  REF_CLK_RST   = 12'd1190;
  localparam logic [WIN_W-1:0] LONG_WIN_RST  = 14'd200;
  localparam logic [WIN_W-1:0] SHORT_WIN_RST = 14'd150;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_CLK   = 2'd0,
    CFG_LONG_WIN  = 2'd1,
    CFG_SHORT_WIN = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_INIT, S_TEST, S_RD, S_MUL, S_ACC,
    S_DIVINIT, S_DIV, S_POST, S_DECIDE
  } st_e;

  typedef struct packed {
    logic accept;
    logic write;
    logic init;
    logic rd;
    logic mul;
    logic acc;
    logic div_init;
    logic div_step;
    logic post;
    logic load_out;
    logic use_short;
  } cmd_t;

  typedef struct packed {
    logic walk_more;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/core_count_hotplug_decider_top.sv
// Core count hotplug decider: one needed core count per load sample.
// One sample is taken at a time. Its result is loaded into the output register
// after a walk of the history and a restoring divide, first for the long and
// then for the short window, and the next sample can be accepted in the cycle
// after that. The divider is $clog2(HISTORY_DEPTH*500+1) + 21 bits wide
// (35 at the default depth, one quotient bit per cycle, run twice). Each walk
// visits at most HISTORY_DEPTH history entries, each through the history RAM
// read port and the multiplier. A finished result waits in an output register,
// and the next sample is accepted while it waits; a later result holds until
// that register is free. Configuration writes are always ready.
module core_count_hotplug_decider_top #(
  parameter int HISTORY_DEPTH = 25
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cchd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cchd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cchd_pkg::LOAD_W-1:0]       core_load_0_i,
  input  logic [cchd_pkg::LOAD_W-1:0]       core_load_1_i,
  input  logic [cchd_pkg::LOAD_W-1:0]       core_load_2_i,
  input  logic [cchd_pkg::LOAD_W-1:0]       core_load_3_i,
  input  logic [cchd_pkg::FREQ_W-1:0]       freq_mhz_i,
  input  logic [cchd_pkg::MS_W-1:0]         elapsed_ms_i,
  input  logic [cchd_pkg::TASK_W-1:0]       running_tasks_i,
  input  logic [cchd_pkg::CNT_W-1:0]        online_count_i,
  input  logic                              sleep_request_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [cchd_pkg::CNT_W-1:0]        needed_count_o,
  output logic [cchd_pkg::AVG_W-1:0]        long_average_o
);
  import cchd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  cchd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  cchd_dp #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .core_load_0_i  (core_load_0_i),
    .core_load_1_i  (core_load_1_i),
    .core_load_2_i  (core_load_2_i),
    .core_load_3_i  (core_load_3_i),
    .freq_mhz_i     (freq_mhz_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .running_tasks_i(running_tasks_i),
    .online_count_i (online_count_i),
    .sleep_request_i(sleep_request_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .needed_count_o (needed_count_o),
    .long_average_o (long_average_o)
  );
endmodule

FILE: hdl/cchd_ram.sv
// Generic single-port-write RAM with registered read.
module cchd_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 25
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: hdl/cchd_ctrl.sv
// Sequencing state machine of the core count hotplug decider.
module cchd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cchd_pkg::sts_t sts_i,
  output cchd_pkg::cmd_t cmd_o
);
  import cchd_pkg::*;

  st_e  state_q, state_d;
  logic short_q, short_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      short_q <= 1'b0;
    end else begin
      state_q <= state_d;
      short_q <= short_d;
    end
  end

  always_comb begin
    state_d = state_q;
    short_d = short_q;
    case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_WRITE;
      S_WRITE: begin
        state_d = S_INIT;
        short_d = 1'b0;
      end
      S_INIT:    state_d = S_TEST;
      S_TEST:    state_d = sts_i.walk_more ? S_RD : S_DIVINIT;
      S_RD:      state_d = S_MUL;
      S_MUL:     state_d = S_ACC;
      S_ACC:     state_d = S_TEST;
      S_DIVINIT: state_d = S_DIV;
      S_DIV:     if (sts_i.div_last) state_d = S_POST;
      S_POST: begin
        if (short_q) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_INIT;
          short_d = 1'b1;
        end
      end
      S_DECIDE:  if (sts_i.out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.use_short = short_q;
    case (state_q)
      S_IDLE:    cmd_o.accept   = in_valid_i;
      S_WRITE:   cmd_o.write    = 1'b1;
      S_INIT:    cmd_o.init     = 1'b1;
      S_RD:      cmd_o.rd       = 1'b1;
      S_MUL:     cmd_o.mul      = 1'b1;
      S_ACC:     cmd_o.acc      = 1'b1;
      S_DIVINIT: cmd_o.div_init = 1'b1;
      S_DIV:     cmd_o.div_step = 1'b1;
      S_POST:    cmd_o.post     = 1'b1;
      S_DECIDE:  cmd_o.load_out = sts_i.out_free;
      default:   cmd_o.accept   = 1'b0;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);
endmodule

FILE: hdl/cchd_dp.sv
// Datapath: history, weighted-average walk, shared divider and core rules.
module cchd_dp #(
  parameter int HISTORY_DEPTH = 25
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cchd_pkg::cmd_t                        cmd_i,
  output cchd_pkg::sts_t                        sts_o,
  input  logic                                  cfg_valid_i,
  input  logic [cchd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [cchd_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic [cchd_pkg::LOAD_W-1:0]           core_load_0_i,
  input  logic [cchd_pkg::LOAD_W-1:0]           core_load_1_i,
  input  logic [cchd_pkg::LOAD_W-1:0]           core_load_2_i,
  input  logic [cchd_pkg::LOAD_W-1:0]           core_load_3_i,
  input  logic [cchd_pkg::FREQ_W-1:0]           freq_mhz_i,
  input  logic [cchd_pkg::MS_W-1:0]             elapsed_ms_i,
  input  logic [cchd_pkg::TASK_W-1:0]           running_tasks_i,
  input  logic [cchd_pkg::CNT_W-1:0]            online_count_i,
  input  logic                                  sleep_request_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [cchd_pkg::CNT_W-1:0]            needed_count_o,
  output logic [cchd_pkg::AVG_W-1:0]            long_average_o
);
  import cchd_pkg::*;

  localparam int PW    = $clog2(HISTORY_DEPTH);
  localparam int NW    = $clog2(HISTORY_DEPTH + 1);
  localparam int COV_W = $clog2(HISTORY_DEPTH * 500 + 1);
  localparam int ACC_W = COV_W + LF_W;
  localparam int DC_W  = $clog2(ACC_W);
  localparam int CMP_W = COV_W + WIN_W;
  localparam int RW    = LF_W + TIME_W;
  localparam int PROD_W = LF_W + TIME_W;
  localparam logic [PW-1:0] LAST_POS = PW'(HISTORY_DEPTH - 1);
  localparam logic [NW-1:0] N_MAX    = NW'(HISTORY_DEPTH);
  localparam logic [DC_W-1:0] DC_LAST = DC_W'(ACC_W - 1);

  logic [MF_W-1:0]  ref_clk_q;
  logic [WIN_W-1:0] long_win_q, short_win_q;

  logic [LOAD_W-1:0] l0_q, l1_q, l2_q, l3_q;
  logic [FREQ_W-1:0] freq_q;
  logic [MS_W-1:0]   ms_q;
  logic [TASK_W-1:0] tasks_q;
  logic [CNT_W-1:0]  online_q;
  logic              sleep_q;

  logic [PW-1:0]     ptr_q, ptr_d;
  logic [HISTORY_DEPTH-1:0] valid_q;
  logic [TASK_W-1:0] t0_q, t1_q, t2_q;

  logic [PW-1:0]     pos_q;
  logic [NW-1:0]     n_q;
  logic [COV_W-1:0]  cov_q;
  logic [ACC_W-1:0]  acc_q;
  logic              rvalid_q;
  logic [PROD_W-1:0] prod_q;
  logic [TIME_W-1:0] tm_q;

  logic [ACC_W-1:0]  quo_q;
  logic [COV_W-1:0]  rem_q;
  logic [DC_W-1:0]   dcnt_q;

  logic [AVG_W-1:0]  avg_long_q, avg_short_q;
  logic              out_valid_q;
  logic [CNT_W-1:0]  need_q;
  logic [AVG_W-1:0]  long_out_q;

  logic [LOAD_W+1:0] load_sum;
  logic [LF_W-1:0]   lf_w;
  logic [TIME_W-1:0] tcap_w;
  logic [RW-1:0]     rdata;
  logic [LF_W-1:0]   lf_rd;
  logic [TIME_W-1:0] t_rd;
  logic [WIN_W-1:0]  win;
  logic [COV_W:0]    trial;
  logic              fits;
  logic [AVG_W-1:0]  div_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_clk_q   <= REF_CLK_RST;
      long_win_q  <= LONG_WIN_RST;
      short_win_q <= SHORT_WIN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_REF_CLK:   ref_clk_q   <= cfg_data_i[MF_W-1:0];
        CFG_LONG_WIN:  long_win_q  <= cfg_data_i[WIN_W-1:0];
        CFG_SHORT_WIN: short_win_q <= cfg_data_i[WIN_W-1:0];
        default:       ref_clk_q   <= ref_clk_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      l0_q     <= core_load_0_i;
      l1_q     <= core_load_1_i;
      l2_q     <= core_load_2_i;
      l3_q     <= core_load_3_i;
      freq_q   <= freq_mhz_i;
      ms_q     <= elapsed_ms_i;
      tasks_q  <= running_tasks_i;
      online_q <= online_count_i;
      sleep_q  <= sleep_request_i;
    end
  end

  assign load_sum = (LOAD_W+2)'(l0_q) + (LOAD_W+2)'(l1_q)
                  + (LOAD_W+2)'(l2_q) + (LOAD_W+2)'(l3_q);
  assign lf_w     = LF_W'(load_sum * freq_q);
  assign tcap_w   = (ms_q > MS_W'(TIME_CAP)) ? TIME_CAP : ms_q[TIME_W-1:0];
  assign ptr_d    = (ptr_q == LAST_POS) ? '0 : ptr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      valid_q <= '0;
      t0_q    <= '0;
      t1_q    <= '0;
      t2_q    <= '0;
    end else if (cmd_i.write) begin
      ptr_q          <= ptr_d;
      valid_q[ptr_d] <= 1'b1;
      t0_q           <= tasks_q;
      t1_q           <= t0_q;
      t2_q           <= t1_q;
    end
  end

  cchd_ram #(
    .WIDTH(RW),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (cmd_i.write),
    .waddr_i(ptr_d),
    .wdata_i({lf_w, tcap_w}),
    .raddr_i(pos_q),
    .rdata_o(rdata)
  );

  assign lf_rd = rvalid_q ? rdata[RW-1:TIME_W] : '0;
  assign t_rd  = rvalid_q ? rdata[TIME_W-1:0] : '0;
  assign win   = cmd_i.use_short ? short_win_q : long_win_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      pos_q <= ptr_q;
      n_q   <= '0;
      cov_q <= '0;
      acc_q <= '0;
    end else if (cmd_i.acc) begin
      pos_q <= (pos_q == '0) ? LAST_POS : pos_q - 1'b1;
      n_q   <= n_q + 1'b1;
      cov_q <= cov_q + COV_W'(tm_q);
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.rd) begin
      rvalid_q <= valid_q[pos_q];
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(lf_rd * t_rd);
      tm_q   <= t_rd;
    end
  end

  assign sts_o.walk_more = ({{WIN_W{1'b0}}, cov_q} < {{COV_W{1'b0}}, win})
                         && (n_q < N_MAX);

  assign trial = {rem_q, quo_q[ACC_W-1]};
  assign fits  = trial >= {1'b0, cov_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      quo_q  <= acc_q;
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= fits ? COV_W'(trial - {1'b0, cov_q}) : trial[COV_W-1:0];
      quo_q  <= {quo_q[ACC_W-2:0], fits};
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  assign sts_o.div_last = (dcnt_q == DC_LAST);
  assign div_res = (cov_q == '0) ? '0 : quo_q[AVG_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.post) begin
      if (cmd_i.use_short) begin
        avg_short_q <= div_res;
      end else begin
        avg_long_q <= div_res;
      end
    end
  end

  logic [AVG_W-1:0]  mf_w;
  logic [AVG_W-1:0]  th80, th150, th160, th200, th240;
  logic [TASK_W+1:0] sum3;
  logic [TASK_W:0]   sum2;
  logic [TX_W-1:0]   rt3x, rt2x;
  logic [LOAD_W:0]   l01;
  logic [CNT_W-1:0]  need;

  assign mf_w  = AVG_W'(ref_clk_q);
  assign th80  = AVG_W'(mf_w * K80);
  assign th150 = AVG_W'(mf_w * K150);
  assign th160 = AVG_W'(mf_w * K160);
  assign th200 = AVG_W'(mf_w * K200);
  assign th240 = AVG_W'(mf_w * K240);
  assign sum2  = (TASK_W+1)'(t0_q) + (TASK_W+1)'(t1_q);
  assign sum3  = (TASK_W+2)'(sum2) + (TASK_W+2)'(t2_q);
  assign rt3x  = TX_W'(sum3) * TX_W'(7'd100);
  assign rt2x  = TX_W'(sum2) * TX_W'(7'd100);
  assign l01   = (LOAD_W+1)'(l0_q) + (LOAD_W+1)'(l1_q);

  always_comb begin
    need = online_q;
    if (sleep_q) begin
      need = 3'd1;
    end else begin
      case (online_q)
        3'd1: begin
          if (freq_q >= UP1_FREQ && l0_q >= UP1_LOAD && avg_long_q > th80
              && rt3x >= UP1_TASKS) begin
            need = 3'd2;
          end
        end
        3'd2: begin
          if (rt3x <= DN2_TASKS && avg_short_q < th80 && l01 < DN2_LOAD) begin
            need = 3'd1;
          end else if (freq_q >= UP23_FREQ && avg_long_q > th160
                       && rt2x >= UP2_TASKS) begin
            need = 3'd3;
          end
        end
        3'd3: begin
          if (rt3x <= DN3_TASKS && avg_short_q <= th150) begin
            need = 3'd2;
          end else if (freq_q >= UP23_FREQ && avg_long_q > th240
                       && rt3x >= UP3_TASKS) begin
            need = 3'd4;
          end
        end
        3'd4: begin
          if (rt3x <= DN4_TASKS && avg_short_q <= th200) begin
            need = 3'd3;
          end
        end
        default: need = online_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      need_q     <= need;
      long_out_q <= avg_long_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign needed_count_o = need_q;
  assign long_average_o = long_out_q;
endmodule

FILE: hdl/cchd_checker.sv
// Port-level checker for the core count hotplug decider, with its bind.
`include "core_count_hotplug_decider_top_assert.svh"

module cchd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [cchd_pkg::CNT_W-1:0]      needed_count_o,
  input logic [cchd_pkg::AVG_W-1:0]      long_average_o
);
  `CCHD_ASSERT_NEXT(busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `CCHD_ASSERT_NOW(ready_when_result_lands, $rose(out_valid_o), !in_stall_o)
  `CCHD_ASSERT_NEXT(result_held_while_stalled, out_valid_o && out_stall_i,
                    out_valid_o && $stable(needed_count_o) && $stable(long_average_o))
endmodule

bind core_count_hotplug_decider_top cchd_checker u_cchd_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for the core count hotplug decider.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cchd_pkg::*;

  localparam int HIST_DEPTH = 25;
  localparam int TASK_DEPTH = 3;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [LOAD_W-1:0] load0;
    logic [LOAD_W-1:0] load1;
    logic [LOAD_W-1:0] load2;
    logic [LOAD_W-1:0] load3;
    logic [FREQ_W-1:0] freq;
    logic [MS_W-1:0]   ms;
    logic [TASK_W-1:0] tasks;
    logic [CNT_W-1:0]  online;
    logic              sleep;
  } sample_t;

  typedef struct packed {
    logic [CNT_W-1:0] needed;
    logic [AVG_W-1:0] avg_long;
  } decision_t;

  class decision_scoreboard;
    decision_t   pending_q[$];
    int          errors;
    int unsigned ref_clk, long_win, short_win;
    int unsigned load_freq_hist[HIST_DEPTH];
    int unsigned time_hist[HIST_DEPTH];
    int unsigned hist_ptr;
    int unsigned task_hist[TASK_DEPTH];
    int unsigned task_ptr;

    function new();
      ref_clk   = REF_CLK_RST;
      long_win  = LONG_WIN_RST;
      short_win = SHORT_WIN_RST;
      hist_ptr  = 0;
      task_ptr  = 0;
      foreach (load_freq_hist[i]) begin
        load_freq_hist[i] = 0;
        time_hist[i] = 0;
      end
      foreach (task_hist[i]) task_hist[i] = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_REF_CLK: begin
          ref_clk = data[MF_W-1:0];
        end
        CFG_LONG_WIN: begin
          long_win = data;
        end
        CFG_SHORT_WIN: begin
          short_win = data;
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned time_weighted_avg(int unsigned win);
      int unsigned pos, covered, n;
      longint unsigned acc;
      pos = hist_ptr;
      covered = 0;
      acc = 0;
      for (n = 0; covered < win && n < HIST_DEPTH; n++) begin
        acc += longint'(load_freq_hist[pos]) * time_hist[pos];
        covered += time_hist[pos];
        pos = (pos == 0) ? HIST_DEPTH - 1 : pos - 1;
      end
      if (covered == 0) return 0;
      return int'(acc / covered);
    endfunction

    function int unsigned task_avg(int unsigned cnt);
      int unsigned pos, total, n;
      pos = task_ptr;
      total = 0;
      for (n = 0; n < cnt; n++) begin
        total += task_hist[pos];
        pos = (pos == 0) ? TASK_DEPTH - 1 : pos - 1;
      end
      return (total * 100) / cnt;
    endfunction

    function void note_sample(sample_t s);
      int unsigned lsum, avg_l, avg_s, rt2, rt3, need, mf;
      decision_t d;
      lsum = s.load0 + s.load1 + s.load2 + s.load3;
      hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
      load_freq_hist[hist_ptr] = (lsum * s.freq) & 32'h1FFFFF;
      time_hist[hist_ptr] = (s.ms > TIME_CAP) ? TIME_CAP : s.ms;
      task_ptr = (task_ptr + 1) % TASK_DEPTH;
      task_hist[task_ptr] = s.tasks;
      avg_l = time_weighted_avg(long_win);
      avg_s = time_weighted_avg(short_win);
      rt2 = task_avg(2);
      rt3 = task_avg(3);
      mf = ref_clk;
      need = s.online;
      if (s.sleep) begin
        need = 1;
      end else if (s.online == 1) begin
        if (s.freq >= 998 && s.load0 >= 80 && avg_l > mf * 80 && rt3 >= 250) need = 2;
      end else if (s.online == 2) begin
        if (rt3 <= 200 && avg_s < mf * 80 && (s.load0 + s.load1) < 80) need = 1;
        else if (s.freq >= 1094 && avg_l > mf * 160 && rt2 >= 350) need = 3;
      end else if (s.online == 3) begin
        if (rt3 <= 300 && avg_s <= mf * 150) need = 2;
        else if (s.freq >= 1094 && avg_l > mf * 240 && rt3 >= 450) need = 4;
      end else if (s.online == 4) begin
        if (rt3 <= 400 && avg_s <= mf * 200) need = 3;
      end
      d.needed = need[CNT_W-1:0];
      d.avg_long = avg_l[AVG_W-1:0];
      pending_q.push_back(d);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_decision(logic [CNT_W-1:0] needed, logic [AVG_W-1:0] avg_long);
      decision_t d;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected transaction needed=%0d avg=%0d", needed, avg_long));
      end else begin
        d = pending_q.pop_front();
        if (needed !== d.needed)
          report($sformatf("needed_count %0d, want %0d", needed, d.needed));
        if (avg_long !== d.avg_long)
          report($sformatf("long_average %0d, want %0d", avg_long, d.avg_long));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  sample_t smp = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [CNT_W-1:0] needed_count_o;
  logic [AVG_W-1:0] long_average_o;

  decision_scoreboard sb = new();
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int rx_left = 0;
  int idle_cycles = 0;

  core_count_hotplug_decider_top u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .core_load_0_i(smp.load0), .core_load_1_i(smp.load1),
    .core_load_2_i(smp.load2), .core_load_3_i(smp.load3),
    .freq_mhz_i(smp.freq), .elapsed_ms_i(smp.ms), .running_tasks_i(smp.tasks),
    .online_count_i(smp.online), .sleep_request_i(smp.sleep),
    .out_valid_o, .out_stall_i, .needed_count_o, .long_average_o
  );

  always #5 clk_i = ~clk_i;

  // result side: check, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_decision(needed_count_o, long_average_o);
      if (hold_req) begin
        hold_req <= 1'b0;
        out_stall_i <= 1'b1;
        rx_left <= 500;
      end else if (rx_left > 0) begin
        rx_left <= rx_left - 1;
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else begin
        int r;
        r = $urandom_range(0, 99);
        out_stall_i <= (r >= 65);
        rx_left <= (r < 65) ? $urandom_range(0, 10) :
                   (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task send_sample(sample_t s);
    int r, gap;
    in_valid_i <= 1'b1;
    smp <= s;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(s);
    r = $urandom_range(0, 99);
    gap = (calm || r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task drain;
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task write_reg(cfg_idx_e idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val[CFG_DATA_W-1:0]);
    cfg_valid_i <= 1'b0;
  endtask

  function sample_t mk(int l0, int l1, int l2, int l3, int f, int ms, int t, int on, int sl);
    sample_t s;
    s.load0 = LOAD_W'(l0); s.load1 = LOAD_W'(l1);
    s.load2 = LOAD_W'(l2); s.load3 = LOAD_W'(l3);
    s.freq = FREQ_W'(f); s.ms = MS_W'(ms); s.tasks = TASK_W'(t);
    s.online = CNT_W'(on); s.sleep = 1'(sl);
    return s;
  endfunction

  function sample_t rand_sample();
    sample_t s;
    bit noisy;
    noisy = ($urandom_range(0, 9) == 0);
    s.load0 = LOAD_W'(noisy ? $urandom_range(0, 127) : $urandom_range(0, 100));
    s.load1 = LOAD_W'(noisy ? $urandom_range(0, 127) : $urandom_range(0, 100));
    s.load2 = LOAD_W'(noisy ? $urandom_range(0, 127) : $urandom_range(0, 100));
    s.load3 = LOAD_W'(noisy ? $urandom_range(0, 127) : $urandom_range(0, 100));
    if ($urandom_range(0, 2) == 0) s.load0 = LOAD_W'($urandom_range(70, 100));
    s.freq = FREQ_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095)
                                                  : $urandom_range(900, 1300));
    s.ms = MS_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 600));
    s.tasks = TASK_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 8));
    s.online = CNT_W'(noisy ? $urandom_range(0, 7) : $urandom_range(1, 4));
    s.sleep = ($urandom_range(0, 9) == 0);
    return s;
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_sample(mk(0, 0, 0, 0, 0, 0, 0, 1, 0));
    send_sample(mk(127, 127, 127, 127, 4095, 65535, 255, 7, 1));
    send_sample(mk(127, 127, 127, 127, 4095, 65535, 255, 0, 0));
    send_sample(mk(100, 100, 100, 100, 4095, 500, 255, 1, 0));
    send_sample(mk(100, 100, 100, 100, 998, 501, 3, 1, 0));
    send_sample(mk(90, 0, 0, 0, 997, 100, 3, 1, 0));
    send_sample(mk(10, 10, 0, 0, 500, 200, 1, 2, 0));
    send_sample(mk(100, 100, 100, 100, 1094, 300, 4, 2, 0));
    send_sample(mk(100, 100, 100, 100, 1094, 300, 4, 2, 0));
    send_sample(mk(100, 100, 100, 100, 1094, 300, 5, 3, 0));
    send_sample(mk(100, 100, 100, 100, 1094, 300, 5, 3, 0));
    send_sample(mk(5, 5, 5, 5, 300, 400, 2, 3, 0));
    send_sample(mk(5, 5, 5, 5, 300, 400, 2, 4, 0));
    send_sample(mk(100, 100, 100, 100, 4095, 400, 9, 4, 0));
    send_sample(mk(50, 50, 50, 50, 1200, 0, 3, 5, 0));
    send_sample(mk(50, 50, 50, 50, 1200, 0, 3, 6, 1));
    drain();
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_REF_CLK, 4095); write_reg(CFG_LONG_WIN, 12500);
          write_reg(CFG_SHORT_WIN, 12500);
        end
        1: begin
          write_reg(CFG_REF_CLK, 1); write_reg(CFG_LONG_WIN, 0);
          write_reg(CFG_SHORT_WIN, 0);
        end
        2: begin
          write_reg(CFG_REF_CLK, 1190); write_reg(CFG_LONG_WIN, 200);
          write_reg(CFG_SHORT_WIN, 150);
        end
        default: begin
          write_reg(CFG_REF_CLK, $urandom_range(1, 4095));
          write_reg(CFG_LONG_WIN, $urandom_range(0, 12500));
          write_reg(CFG_SHORT_WIN, $urandom_range(0, 2000));
        end
      endcase
      calm = (ph == 4);
      if (ph == 3) hold_req <= 1'b1;
      repeat (105) send_sample(rand_sample());
      drain();
    end
    calm = 1'b0;
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
